/* hw/rtl/xml_markup_tokenizer_macros.svh */
// Assertion macros used by the checker of the tokenizer.
`ifndef XML_MARKUP_TOKENIZER_MACROS_SVH
`define XML_MARKUP_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define XMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define XMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/xmt_pkg.sv */
package xmt_pkg;

  // Largest document; the byte at DOC_BYTES-1 always ends it.
  localparam longint DOC_BYTES = 65536;
  localparam int POS_W = $clog2(DOC_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DOC_BYTES - 1);

  localparam int TOK_W = 16;

  // Result queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);
  localparam logic [Q_CW-1:0] Q_READY_MAX = Q_CW'(Q_DEPTH - 2);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [POS_W:0] pos_x_t;

  typedef enum logic [3:0] {
    M_IDLE, M_TEXT, M_LT, M_TAG_NAME, M_TAG_ATTR, M_CLOSE_NAME, M_CLOSE_ATTR,
    M_DIRECTIVE, M_BANG, M_COMMENT_PFX, M_CDATA_PFX, M_COMMENT, M_CDATA
  } scan_mode_t;

  typedef enum logic [2:0] {
    K_OPEN  = 3'd0,
    K_SELF  = 3'd1,
    K_CLOSE = 3'd2,
    K_TEXT  = 3'd3,
    K_END   = 3'd4,
    K_ERROR = 3'd5
  } tok_kind_t;

  typedef enum logic [2:0] {
    E_NONE         = 3'd0,
    E_OPEN_TAG     = 3'd1,
    E_OPEN_COMMENT = 3'd2,
    E_OPEN_CDATA   = 3'd3,
    E_BAD_MARKUP   = 3'd4
  } err_code_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [3:0] CDATA_LEN = 4'd9;
  localparam logic [3:0] CDATA_AFTER_BRACK = 4'd3;
  localparam logic [3:0] CLOSER_RUN = 4'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    tok_kind_t        token_kind;
    logic [TOK_W-1:0] token_start;
    logic [TOK_W-1:0] token_length;
    err_code_t        error_code;
    logic             run_last;
  } out_item_t;

  // Bytes of "<![CDATA[" by position; positions past the end give nul,
  // which never matches a content byte.
  function automatic logic [7:0] cdata_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CH_LT;
      4'd1:    c = CH_BANG;
      4'd2:    c = CH_LBRACK;
      4'd3:    c = 8'h43;
      4'd4:    c = 8'h44;
      4'd5:    c = 8'h41;
      4'd6:    c = 8'h54;
      4'd7:    c = 8'h41;
      4'd8:    c = CH_LBRACK;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic out_item_t mk_res(input tok_kind_t kind, input pos_x_t start,
                                       input pos_x_t len, input err_code_t err);
    out_item_t r;
    r.token_kind   = kind;
    r.token_start  = TOK_W'(start);
    r.token_length = TOK_W'(len);
    r.error_code   = err;
    r.run_last     = 1'b0;
    return r;
  endfunction

endpackage

/* hw/rtl/xml_markup_tokenizer.sv */
// Streaming XML markup tokenizer. It takes one document byte per cycle and
// reports open, self-closing and close tags, text (CDATA sections count as
// text, markers included), a final end token, or an error token that stops
// the block until reset. Each token is a kind plus the offset and length of
// its text. Comments and <? > directives are skipped without a token. A nul
// byte, a byte flagged last, or the byte at offset DOC_BYTES-1 ends the
// document. The scanner state is updated in the cycle a byte is accepted and
// its results land in a four-entry result queue, so the first result can be
// taken in the cycle after the byte. The input side sustains one byte per
// clock; in_ready falls only when the queue holds three or more results,
// which happens when the output side stalls. A byte gives at most one
// result, except the one that ends the document, which may give a tag or
// text token, then the end or error token; run_last marks the last result
// of each byte. After the end or an error, bytes are still taken but ignored.
module xml_markup_tokenizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  xmt_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output xmt_pkg::out_item_t out_data
);
  import xmt_pkg::*;

  // Scanner state.
  scan_mode_t scan_mode, scan_mode_next;
  pos_t       byte_position;
  pos_t       token_origin, token_origin_next;
  pos_t       name_stop, name_stop_next;
  pos_t       last_nonblank, last_nonblank_next;
  logic [7:0] previous_byte;
  logic [3:0] match_count, match_count_next;
  logic       halted, halted_next;
  logic       byte_fail;

  // Result queue.
  out_item_t       q [Q_DEPTH];
  logic [Q_AW-1:0] q_head, q_tail;
  logic [Q_CW-1:0] q_count;

  logic       in_fire, out_fire, work;
  logic [7:0] b;
  pos_t       pos;
  logic       doc_end;

  // Candidate results: one from the byte itself, then up to two from the
  // end of the document (pending text or an error, then the end token).
  logic      t_vld, f_vld, e_vld;
  out_item_t t_res, f_res, e_res;
  out_item_t res0, res1;
  logic [1:0] res_n, push_n;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign work     = in_fire && !halted;

  assign b       = in_data.in_byte;
  assign pos     = byte_position;
  assign doc_end = in_data.in_last || (pos == LAST_POS);

  // Next scanner state.
  always_comb begin
    scan_mode_next     = scan_mode;
    token_origin_next  = token_origin;
    name_stop_next     = name_stop;
    last_nonblank_next = last_nonblank;
    match_count_next   = match_count;
    byte_fail          = 1'b0;

    if (b != CH_NUL) begin
      unique case (scan_mode) inside
        M_IDLE: begin
          if (!is_blank(b)) begin
            token_origin_next = pos;
            if (b == CH_LT) begin
              scan_mode_next = M_LT;
            end else begin
              scan_mode_next     = M_TEXT;
              last_nonblank_next = pos;
            end
          end
        end
        M_TEXT: begin
          if (b == CH_LT) begin
            token_origin_next = pos;
            scan_mode_next    = M_LT;
          end else if (!is_blank(b)) begin
            // Trailing blanks are trimmed because last_nonblank only moves
            // on content bytes.
            last_nonblank_next = pos;
          end
        end
        M_LT, M_TAG_NAME, M_TAG_ATTR: begin
          if (b == CH_QUEST && scan_mode == M_LT) begin
            scan_mode_next = M_DIRECTIVE;
          end else if (b == CH_SLASH && scan_mode == M_LT) begin
            scan_mode_next = M_CLOSE_NAME;
          end else if (b == CH_BANG && scan_mode == M_LT) begin
            scan_mode_next = M_BANG;
          end else if (b == CH_GT) begin
            // The name ends at '>' unless a blank already ended it.
            if (scan_mode != M_TAG_ATTR) begin
              name_stop_next = pos;
            end
            scan_mode_next = M_IDLE;
          end else if (is_blank(b) && scan_mode != M_TAG_ATTR) begin
            name_stop_next = pos;
            scan_mode_next = M_TAG_ATTR;
          end else if (scan_mode == M_LT) begin
            scan_mode_next = M_TAG_NAME;
          end
        end
        M_CLOSE_NAME, M_CLOSE_ATTR: begin
          if (b == CH_GT) begin
            if (scan_mode == M_CLOSE_NAME) begin
              name_stop_next = pos;
            end
            scan_mode_next = M_IDLE;
          end else if (is_blank(b) && scan_mode == M_CLOSE_NAME) begin
            name_stop_next = pos;
            scan_mode_next = M_CLOSE_ATTR;
          end
        end
        M_DIRECTIVE: begin
          if (b == CH_GT) begin
            scan_mode_next = M_IDLE;
          end
        end
        M_BANG: begin
          if (b == CH_DASH) begin
            scan_mode_next = M_COMMENT_PFX;
          end else if (b == CH_LBRACK) begin
            scan_mode_next   = M_CDATA_PFX;
            match_count_next = CDATA_AFTER_BRACK;
          end else begin
            byte_fail = 1'b1;
          end
        end
        M_COMMENT_PFX: begin
          if (b == CH_DASH) begin
            scan_mode_next   = M_COMMENT;
            match_count_next = '0;
          end else begin
            byte_fail = 1'b1;
          end
        end
        M_CDATA_PFX: begin
          if (b == cdata_char(match_count)) begin
            if (match_count + 4'd1 == CDATA_LEN) begin
              scan_mode_next   = M_CDATA;
              match_count_next = '0;
            end else begin
              match_count_next = match_count + 4'd1;
            end
          end else begin
            byte_fail = 1'b1;
          end
        end
        M_COMMENT: begin
          if (b == CH_DASH) begin
            if (match_count < CLOSER_RUN) begin
              match_count_next = match_count + 4'd1;
            end
          end else if (b == CH_GT && match_count >= CLOSER_RUN) begin
            scan_mode_next = M_IDLE;
          end else begin
            match_count_next = '0;
          end
        end
        M_CDATA: begin
          if (b == CH_RBRACK) begin
            if (match_count < CLOSER_RUN) begin
              match_count_next = match_count + 4'd1;
            end
          end else if (b == CH_GT && match_count >= CLOSER_RUN) begin
            scan_mode_next = M_IDLE;
          end else begin
            match_count_next = '0;
          end
        end
        default: begin
          scan_mode_next = M_IDLE;
        end
      endcase
    end

    // Bad markup, a nul byte or the end of the document stops the scanner.
    halted_next = halted || byte_fail || (b == CH_NUL) || doc_end;
  end

  // Results the byte causes.
  always_comb begin
    t_vld = 1'b0;
    f_vld = 1'b0;
    e_vld = 1'b0;
    t_res = '0;
    f_res = '0;
    e_res = '0;

    if (b != CH_NUL) begin
      unique case (scan_mode) inside
        M_TEXT: begin
          if (b == CH_LT) begin
            t_vld = 1'b1;
            t_res = mk_res(K_TEXT, pos_x_t'(token_origin),
                           pos_x_t'(last_nonblank) + pos_x_t'(1) - pos_x_t'(token_origin),
                           E_NONE);
          end
        end
        M_LT, M_TAG_NAME, M_TAG_ATTR: begin
          if (b == CH_GT) begin
            t_vld = 1'b1;
            t_res = mk_res((previous_byte == CH_SLASH) ? K_SELF : K_OPEN,
                           pos_x_t'(token_origin) + pos_x_t'(1),
                           pos_x_t'(name_stop_next) - pos_x_t'(token_origin) - pos_x_t'(1),
                           E_NONE);
          end
        end
        M_CLOSE_NAME, M_CLOSE_ATTR: begin
          if (b == CH_GT) begin
            t_vld = 1'b1;
            t_res = mk_res(K_CLOSE, pos_x_t'(token_origin) + pos_x_t'(2),
                           pos_x_t'(name_stop_next) - pos_x_t'(token_origin) - pos_x_t'(2),
                           E_NONE);
          end
        end
        M_CDATA: begin
          if (b == CH_GT && match_count >= CLOSER_RUN) begin
            // The whole section, markers included, is one text token.
            t_vld = 1'b1;
            t_res = mk_res(K_TEXT, pos_x_t'(token_origin),
                           pos_x_t'(pos) + pos_x_t'(1) - pos_x_t'(token_origin), E_NONE);
          end
        end
        default: begin
        end
      endcase
    end

    // A "<!" sequence that is neither a comment nor CDATA points at its '<'.
    if (byte_fail) begin
      t_vld = 1'b1;
      t_res = mk_res(K_ERROR, pos_x_t'(token_origin), '0, E_BAD_MARKUP);
    end

    // End of document: flush pending text, or flag whatever is still open.
    if (!halted && !byte_fail && (b == CH_NUL || doc_end)) begin
      unique case (scan_mode_next) inside
        M_IDLE: begin
          e_vld = 1'b1;
        end
        M_TEXT: begin
          f_vld = 1'b1;
          f_res = mk_res(K_TEXT, pos_x_t'(token_origin_next),
                         pos_x_t'(last_nonblank_next) + pos_x_t'(1)
                           - pos_x_t'(token_origin_next),
                         E_NONE);
          e_vld = 1'b1;
        end
        M_BANG, M_COMMENT_PFX, M_CDATA_PFX: begin
          f_vld = 1'b1;
          f_res = mk_res(K_ERROR, pos_x_t'(token_origin_next), '0, E_BAD_MARKUP);
        end
        M_COMMENT: begin
          f_vld = 1'b1;
          f_res = mk_res(K_ERROR, pos_x_t'(token_origin_next), '0, E_OPEN_COMMENT);
        end
        M_CDATA: begin
          f_vld = 1'b1;
          f_res = mk_res(K_ERROR, pos_x_t'(token_origin_next), '0, E_OPEN_CDATA);
        end
        default: begin
          f_vld = 1'b1;
          f_res = mk_res(K_ERROR, pos_x_t'(token_origin_next), '0, E_OPEN_TAG);
        end
      endcase
      // The end token sits at the nul byte, or one past the last byte.
      e_res = mk_res(K_END, (b == CH_NUL) ? pos_x_t'(pos) : pos_x_t'(pos) + pos_x_t'(1),
                     '0, E_NONE);
    end
  end

  // Pack the candidates into at most two queue slots, in order. Only the
  // byte that ends the document can fill both.
  always_comb begin
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    if (t_vld) begin
      res0  = t_res;
      res_n = 2'd1;
    end
    if (f_vld) begin
      if (res_n == 2'd0) begin
        res0 = f_res;
      end else begin
        res1 = f_res;
      end
      res_n = res_n + 2'd1;
    end
    if (e_vld) begin
      if (res_n == 2'd0) begin
        res0 = e_res;
      end else begin
        res1 = e_res;
      end
      res_n = res_n + 2'd1;
    end
    if (res_n == 2'd1) begin
      res0.run_last = 1'b1;
    end
    if (res_n == 2'd2) begin
      res1.run_last = 1'b1;
    end
    push_n = work ? res_n : 2'd0;
  end

  // Scanner registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= M_IDLE;
      byte_position <= '0;
      token_origin  <= '0;
      name_stop     <= '0;
      last_nonblank <= '0;
      previous_byte <= '0;
      match_count   <= '0;
      halted        <= 1'b0;
    end else if (work) begin
      scan_mode     <= scan_mode_next;
      byte_position <= byte_position + pos_t'(1);
      token_origin  <= token_origin_next;
      name_stop     <= name_stop_next;
      last_nonblank <= last_nonblank_next;
      previous_byte <= b;
      match_count   <= match_count_next;
      halted        <= halted_next;
    end
  end

  // Queue control. Ready leaves room for the two results of a final byte.
  assign in_ready  = (q_count <= Q_READY_MAX);
  assign out_valid = (q_count != '0);
  assign out_data  = q[q_head];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      if (out_fire) begin
        q_head <= q_head + Q_AW'(1);
      end
      q_tail  <= q_tail + Q_AW'(push_n);
      q_count <= q_count + Q_CW'(push_n) - Q_CW'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[q_tail] <= res0;
    end
    if (push_n == 2'd2) begin
      q[q_tail + Q_AW'(1)] <= res1;
    end
  end

endmodule

/* hw/rtl/xmt_checker.sv */
`include "xml_markup_tokenizer_macros.svh"

module xmt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input xmt_pkg::out_item_t out_data
);
  import xmt_pkg::*;

  logic out_fire, stop_tok;

  assign out_fire = out_valid && out_ready;
  assign stop_tok = (out_data.token_kind == K_END) || (out_data.token_kind == K_ERROR);

  // A held result stays put until the transaction completes.
  `XMT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // The end or error token is the last result of the document.
  `XMT_ASSERT_NEXT(a_stop_final, clk, rst, out_fire && stop_tok, !out_valid, "result after end or error token")

  // End and error tokens carry no text and close out their byte.
  `XMT_ASSERT_SAME(a_stop_shape, clk, rst, out_valid && stop_tok, (out_data.token_length == '0) && out_data.run_last, "malformed end or error token")

  // Only error tokens carry an error code.
  `XMT_ASSERT_SAME(a_err_code, clk, rst, out_valid && (out_data.token_kind != K_ERROR), out_data.error_code == E_NONE, "error code on a non-error token")

  // The queue is empty after reset, so input is taken at once.
  `XMT_ASSERT_SAME(a_ready_after_rst, clk, rst, $past(rst), in_ready, "not ready after reset")

endmodule

bind xml_markup_tokenizer xmt_checker u_xmt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/xml_markup_tokenizer_tb.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xmt_pkg::*;

  // Kinds of well-formed markup that the random document is built from.
  typedef enum int {
    FR_OPEN, FR_SELF, FR_CLOSE, FR_COMMENT, FR_CDATA, FR_PI
  } fragment_t;

  // Opening marker of a CDATA section, first byte in the top bits.
  localparam logic [71:0] CDATA_OPEN = "<![CDATA[";
  localparam int CDATA_OPEN_LEN = 9;
  localparam int MAX_GAP = 18;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  xml_markup_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer model. It tracks the scanner state of the block and, for every
  // byte the block accepts, appends the tokens that byte causes to the queue
  // of expected tokens. The byte offset is kept wider than the token fields,
  // and offsets and lengths are cut to 16 bits only when a token is formed.
  // ---------------------------------------------------------------------------
  scan_mode_t  scan_mode = M_IDLE;
  int unsigned doc_pos = 0;       // offset of the next byte
  int unsigned tok_origin = 0;    // offset of the '<' or first text byte
  int unsigned name_end = 0;      // offset of the byte that ended a tag name
  int unsigned text_end = 0;      // offset of the last non-blank text byte
  logic [7:0]  prev_byte = 8'h00;
  int unsigned run_count = 0;     // matched prefix bytes or closing run
  bit          doc_done = 1'b0;   // end or error seen; later bytes are ignored

  out_item_t   expected_tokens[$];
  out_item_t   byte_tokens[$];    // tokens caused by the byte being modeled

  int          mismatches = 0;
  int          bytes_sent = 0;
  bit          tx_eager = 1'b0;   // sender offers items back to back
  bit          rx_eager = 1'b0;   // receiver is always ready
  int          rx_hold_cycles = 0;

  function automatic bit blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic [7:0] cdata_open_byte(input int unsigned idx);
    return CDATA_OPEN[71 - 8 * idx -: 8];
  endfunction

  function automatic void add_token(input tok_kind_t kind, input int unsigned start,
                                    input int unsigned len, input err_code_t err);
    out_item_t t;
    t.token_kind   = kind;
    t.token_start  = TOK_W'(start);
    t.token_length = TOK_W'(len);
    t.error_code   = err;
    t.run_last     = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  // An error always points at the '<' that opened the failing construct.
  function automatic void fail_doc(input err_code_t err);
    add_token(K_ERROR, tok_origin, 0, err);
    doc_done = 1'b1;
  endfunction

  // A '>' right after a '/' makes the tag self-closing.
  function automatic void finish_tag();
    tok_kind_t kind;
    kind = (prev_byte == CH_SLASH) ? K_SELF : K_OPEN;
    add_token(kind, tok_origin + 1, name_end - tok_origin - 1, E_NONE);
    scan_mode = M_IDLE;
  endfunction

  function automatic void finish_close_tag();
    add_token(K_CLOSE, tok_origin + 2, name_end - tok_origin - 2, E_NONE);
    scan_mode = M_IDLE;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input int unsigned at);
    case (scan_mode)
      M_IDLE: begin
        if (!blank_char(b)) begin
          tok_origin = at;
          if (b == CH_LT) begin
            scan_mode = M_LT;
          end else begin
            scan_mode = M_TEXT;
            text_end = at;
          end
        end
      end
      M_TEXT: begin
        if (b == CH_LT) begin
          add_token(K_TEXT, tok_origin, text_end + 1 - tok_origin, E_NONE);
          tok_origin = at;
          scan_mode = M_LT;
        end else if (!blank_char(b)) begin
          text_end = at;
        end
      end
      M_LT: begin
        if (b == CH_QUEST) begin
          scan_mode = M_DIRECTIVE;
        end else if (b == CH_SLASH) begin
          scan_mode = M_CLOSE_NAME;
        end else if (b == CH_BANG) begin
          scan_mode = M_BANG;
        end else if (b == CH_GT) begin
          name_end = at;
          finish_tag();
        end else if (blank_char(b)) begin
          name_end = at;
          scan_mode = M_TAG_ATTR;
        end else begin
          scan_mode = M_TAG_NAME;
        end
      end
      M_TAG_NAME: begin
        if (b == CH_GT) begin
          name_end = at;
          finish_tag();
        end else if (blank_char(b)) begin
          name_end = at;
          scan_mode = M_TAG_ATTR;
        end
      end
      M_TAG_ATTR: begin
        if (b == CH_GT) finish_tag();
      end
      M_CLOSE_NAME: begin
        if (b == CH_GT) begin
          name_end = at;
          finish_close_tag();
        end else if (blank_char(b)) begin
          name_end = at;
          scan_mode = M_CLOSE_ATTR;
        end
      end
      M_CLOSE_ATTR: begin
        if (b == CH_GT) finish_close_tag();
      end
      M_DIRECTIVE: begin
        if (b == CH_GT) scan_mode = M_IDLE;
      end
      M_BANG: begin
        if (b == CH_DASH) begin
          scan_mode = M_COMMENT_PFX;
        end else if (b == CH_LBRACK) begin
          // "<![" is already matched against the CDATA marker.
          scan_mode = M_CDATA_PFX;
          run_count = 3;
        end else begin
          fail_doc(E_BAD_MARKUP);
        end
      end
      M_COMMENT_PFX: begin
        if (b == CH_DASH) begin
          scan_mode = M_COMMENT;
          run_count = 0;
        end else begin
          fail_doc(E_BAD_MARKUP);
        end
      end
      M_CDATA_PFX: begin
        if (run_count < CDATA_OPEN_LEN && b == cdata_open_byte(run_count)) begin
          run_count++;
          if (run_count == CDATA_OPEN_LEN) begin
            scan_mode = M_CDATA;
            run_count = 0;
          end
        end else begin
          fail_doc(E_BAD_MARKUP);
        end
      end
      M_COMMENT: begin
        if (b == CH_DASH) begin
          if (run_count < 2) run_count++;
        end else if (b == CH_GT && run_count >= 2) begin
          scan_mode = M_IDLE;
        end else begin
          run_count = 0;
        end
      end
      M_CDATA: begin
        if (b == CH_RBRACK) begin
          if (run_count < 2) run_count++;
        end else if (b == CH_GT && run_count >= 2) begin
          // The text token covers the whole section, markers included.
          add_token(K_TEXT, tok_origin, at + 1 - tok_origin, E_NONE);
          scan_mode = M_IDLE;
        end else begin
          run_count = 0;
        end
      end
      default: scan_mode = M_IDLE;
    endcase
  endfunction

  // End of document: pending text goes out first, then the end token, unless
  // a construct is still open, which is an error instead.
  function automatic void close_document(input int unsigned end_at);
    case (scan_mode)
      M_IDLE: ;
      M_TEXT: add_token(K_TEXT, tok_origin, text_end + 1 - tok_origin, E_NONE);
      M_BANG, M_COMMENT_PFX, M_CDATA_PFX: begin
        fail_doc(E_BAD_MARKUP);
        return;
      end
      M_COMMENT: begin
        fail_doc(E_OPEN_COMMENT);
        return;
      end
      M_CDATA: begin
        fail_doc(E_OPEN_CDATA);
        return;
      end
      default: begin
        fail_doc(E_OPEN_TAG);
        return;
      end
    endcase
    add_token(K_END, end_at, 0, E_NONE);
    doc_done = 1'b1;
  endfunction

  function automatic void predict_tokens(input logic [7:0] b, input logic last);
    int unsigned at;
    bit          ends;
    byte_tokens.delete();
    if (doc_done) return;
    at = doc_pos;
    // The byte at the top of the offset range ends the document regardless.
    ends = last || (at + 1 >= DOC_BYTES);
    if (b != CH_NUL) scan_byte(b, at);
    if (!doc_done && (b == CH_NUL || ends)) close_document((b == CH_NUL) ? at : at + 1);
    prev_byte = b;
    doc_pos = at + 1;
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking. Every accepted result is matched against the oldest expected
  // token. Every mismatch is printed and counted.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token field %s is %0h, expected %0h", field, got, want));
    end
  endtask

  out_item_t oldest_token;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token of kind %0d at %0d with none expected",
                                  out_data.token_kind, out_data.token_start));
      end else begin
        oldest_token = expected_tokens.pop_front();
        check_field("token_kind", 32'(out_data.token_kind),
                    32'(oldest_token.token_kind));
        check_field("token_start", 32'(out_data.token_start),
                    32'(oldest_token.token_start));
        check_field("token_length", 32'(out_data.token_length),
                    32'(oldest_token.token_length));
        check_field("error_code", 32'(out_data.error_code),
                    32'(oldest_token.error_code));
        check_field("run_last", 32'(out_data.run_last), 32'(oldest_token.run_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. For every result it draws a stall before raising ready, unless
  // it runs eager. A hold-off request from a test replaces one draw, so the
  // result queue of the block fills up and its input side stalls.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. One transaction per document byte, after a random gap. Valid is
  // only lowered by a gap or a pause, never in the step that raises it again.
  // The byte is fed to the model at the edge where the block accepts it.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int       gap;
    in_item_t item;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.in_byte = b;
    item.in_last = last;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_tokens(b, last);
    bytes_sent++;
  endtask

  // The flag ends_doc marks the final character as the last byte.
  task automatic send_text(input string s, input bit ends_doc);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends_doc && (i == s.len() - 1));
  endtask

  // The sender stops offering until every expected token has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Any content byte that cannot start markup or end the document.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_LT);
    return b;
  endfunction

  // A tag name byte that cannot turn the tag into another kind or end it.
  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do begin
      b = text_byte();
    end while (blank_char(b) || b == CH_GT || b == CH_SLASH || b == CH_BANG ||
               b == CH_QUEST);
    return b;
  endfunction

  // Inside a tag or directive everything but '>' is inert, '<' included.
  function automatic logic [7:0] attr_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_GT);
    return b;
  endfunction

  // Comment and CDATA bodies lean on the bytes of their closing marker.
  function automatic logic [7:0] body_byte(input logic [7:0] marker);
    case ($urandom_range(0, 5))
      0, 1: return marker;
      2: return CH_GT;
      default: return text_byte();
    endcase
  endfunction

  task automatic send_text_run(input int max_len);
    int n;
    n = $urandom_range(1, max_len);
    repeat (n) send_byte(($urandom_range(0, 3) == 0) ? blank_byte() : text_byte(), 1'b0);
  endtask

  task automatic send_markup(input fragment_t kind);
    int n;
    case (kind)
      FR_OPEN, FR_SELF, FR_CLOSE: begin
        send_byte(CH_LT, 1'b0);
        if (kind == FR_CLOSE) send_byte(CH_SLASH, 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) send_byte(name_byte(), 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          send_byte(blank_byte(), 1'b0);
          n = $urandom_range(0, 8);
          repeat (n) send_byte(attr_byte(), 1'b0);
        end
        if (kind == FR_SELF) send_byte(CH_SLASH, 1'b0);
        send_byte(CH_GT, 1'b0);
      end
      FR_COMMENT: begin
        send_text("<!--", 1'b0);
        n = $urandom_range(0, 10);
        repeat (n) send_byte(body_byte(CH_DASH), 1'b0);
        send_text("-->", 1'b0);
      end
      FR_CDATA: begin
        send_text("<![CDATA[", 1'b0);
        n = $urandom_range(0, 10);
        repeat (n) send_byte(body_byte(CH_RBRACK), 1'b0);
        send_text("]]>", 1'b0);
      end
      default: begin
        send_text("<?", 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) send_byte(attr_byte(), 1'b0);
        send_byte(CH_GT, 1'b0);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every token form once: an empty open tag, an empty self-closing tag with
  // a blank before the slash, a close tag with a blank after its name, text
  // made of the extreme byte values with trailing blanks to trim, an empty
  // comment and an empty CDATA section.
  task automatic test_markup_forms();
    send_text("<>< /></a\t>", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_text(" \015<!----><![CDATA[]]>", 1'b0);
  endtask

  // The receiver holds off for a long stretch while short tags arrive back
  // to back, so the block must stall its input as its queue fills up.
  task automatic test_output_backpressure();
    rx_hold_cycles = 150;
    tx_eager = 1'b1;
    repeat (20) begin
      send_byte(CH_LT, 1'b0);
      send_byte(name_byte(), 1'b0);
      send_byte(CH_GT, 1'b0);
    end
    tx_eager = 1'b0;
    drain_results();
  endtask

  // Mostly well-formed markup with random content, mixed with loose text,
  // stray closing markers and tags that lack their '>'. Either side switches
  // between random gaps and eager runs, and now and then the sender pauses
  // until the block has delivered every token.
  task automatic test_random_document();
    while (bytes_sent < 660) begin
      if ($urandom_range(0, 7) == 0) tx_eager = !tx_eager;
      if ($urandom_range(0, 7) == 0) rx_eager = !rx_eager;
      if ($urandom_range(0, 49) == 0) drain_results();
      case ($urandom_range(0, 11))
        0, 1: send_text_run(($urandom_range(0, 9) == 0) ? 120 : 10);
        2: repeat ($urandom_range(1, 3)) send_byte(blank_byte(), 1'b0);
        3: begin
          send_byte(CH_LT, 1'b0);
          repeat ($urandom_range(1, 3)) send_byte(name_byte(), 1'b0);
        end
        4: send_text(($urandom_range(0, 1) == 1) ? "]]>" : "-->", 1'b0);
        default: send_markup(fragment_t'($urandom_range(0, 5)));
      endcase
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    // A tag left without its '>' is closed so that the ending starts clean.
    if (scan_mode != M_IDLE && scan_mode != M_TEXT) send_byte(CH_GT, 1'b0);
  endtask

  // Only one way to end the document fits in a run, since the block halts
  // until reset; the seed picks which.
  task automatic test_document_end();
    case ($urandom_range(0, 8))
      0: begin
        // Nul byte, after text or between tokens.
        if ($urandom_range(0, 1) == 1) send_text_run(8);
        send_byte(CH_NUL, 1'($urandom_range(0, 1)));
      end
      1: begin
        // Last byte is a trailing blank of text: text first, then the end.
        send_text_run(8);
        send_byte(blank_byte(), 1'b0);
        send_byte(blank_byte(), 1'b1);
      end
      2: send_text("<e/>", 1'b1);
      3: begin
        // Unterminated open tag, close tag or directive.
        case ($urandom_range(0, 3))
          0: send_text("<ab", 1'b1);
          1: send_text("</a", 1'b1);
          2: send_text("<?x", 1'b1);
          default: send_text("< x", 1'b1);
        endcase
      end
      4: send_text("<!--x-", 1'b1);
      5: send_text("<![CDATA[x]", 1'b1);
      6: send_text("<![CD", 1'b1);
      7: send_text(($urandom_range(0, 1) == 1) ? "<!x" : "<!-x", 1'b0);
      default: send_byte(blank_byte(), 1'b1);
    endcase
  endtask

  // After the end or an error the block takes bytes but gives no token.
  task automatic test_bytes_after_end();
    repeat (12) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_markup_forms();
    test_output_backpressure();
    test_random_document();
    test_document_end();
    test_bytes_after_end();
    drain_results();
    // Any token that arrives late would show up as unexpected here.
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
